### hw/rtl/lsmm_pkg.sv
// Package for the lidar sector minimum/mean block.
// Holds the sector codes, register indexes, reset values and shared structs.
// No dependencies.
package lsmm_pkg;

	localparam int NUM_SECTORS = 6;
	localparam int SEC_W       = 3;
	localparam int ACC_EXTRA   = 10;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [SEC_W-1:0] SEC_FRONT       = 3'd0;
	localparam logic [SEC_W-1:0] SEC_FRONT_RIGHT = 3'd1;
	localparam logic [SEC_W-1:0] SEC_REAR_RIGHT  = 3'd2;
	localparam logic [SEC_W-1:0] SEC_REAR        = 3'd3;
	localparam logic [SEC_W-1:0] SEC_REAR_LEFT   = 3'd4;
	localparam logic [SEC_W-1:0] SEC_FRONT_LEFT  = 3'd5;

	localparam int SPS_W      = 11;
	localparam int RANGE_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_SCAN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_MODE        = 2'd2;

	localparam logic MODE_MIN  = 1'b0;
	localparam logic MODE_MEAN = 1'b1;

	localparam logic [SPS_W-1:0]   SPS_RST   = 11'd360;
	localparam logic [RANGE_W-1:0] RANGE_RST = 16'd8000;
	localparam logic               MODE_RST  = MODE_MIN;

	typedef struct packed {
		logic [SPS_W-1:0]   samples_per_scan;
		logic [RANGE_W-1:0] range_limit;
		logic               zone_mode;
	} lsmm_cfg_t;

	typedef struct packed {
		logic [SEC_W-1:0] sector;
		logic             hit;
		logic             last;
		logic             mode;
	} lsmm_tag_t;

endpackage

### hw/rtl/lidar_sector_min_mean_top.sv
// Top level of the lidar sector minimum/mean block: configuration registers,
// front classifier, request queue and accumulating back. Depends on lsmm_pkg.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid, in_ready, distance               | sink
//   out     | out_valid, out_ready, six sectors, empty   | source
//   cfg     | cfg_wr_en, cfg_index, cfg_data             | sink, write only
//
// One sample request is taken per cycle while the four-entry queue has room.
// At scan end the back visits the six sectors in turn, in minimum mode without
// division and in mean mode through the shared bit-serial divider for each nonempty
// sector; the front keeps filling the queue meanwhile.
// A waiting result stalls only the next scan end; reset loads the accumulators
// with the reset range limit.
module lidar_sector_min_mean_top import lsmm_pkg::*; #(
	parameter int MAX_SAMPLES   = 1024,
	parameter int DISTANCE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [DISTANCE_BITS-1:0] distance,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [DISTANCE_BITS-1:0] front,
	output logic [DISTANCE_BITS-1:0] front_right,
	output logic [DISTANCE_BITS-1:0] rear_right,
	output logic [DISTANCE_BITS-1:0] rear,
	output logic [DISTANCE_BITS-1:0] rear_left,
	output logic [DISTANCE_BITS-1:0] front_left,
	output logic [NUM_SECTORS-1:0]   empty_sectors
);

	localparam int TAG_W = $bits(lsmm_tag_t);
	localparam int Q_W   = TAG_W + DISTANCE_BITS;

	lsmm_cfg_t                cfg_q;
	logic                     q_push;
	logic                     q_pop;
	logic                     q_full;
	logic                     q_empty;
	lsmm_tag_t                push_tag;
	logic [DISTANCE_BITS-1:0] push_dist;
	logic [Q_W-1:0]           q_rdata;
	lsmm_tag_t                pop_tag;
	logic [DISTANCE_BITS-1:0] pop_dist;
	logic [DISTANCE_BITS-1:0] sector_val [NUM_SECTORS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_per_scan <= SPS_RST;
			cfg_q.range_limit      <= RANGE_RST;
			cfg_q.zone_mode        <= MODE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SAMPLES_PER_SCAN: cfg_q.samples_per_scan <= cfg_data[SPS_W-1:0];
				REG_RANGE_LIMIT:      cfg_q.range_limit      <= cfg_data[RANGE_W-1:0];
				REG_ZONE_MODE:        cfg_q.zone_mode        <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	lsmm_front #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.DISTANCE_BITS(DISTANCE_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.distance(distance),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_tag   (push_tag),
		.q_dist  (push_dist)
	);

	lsmm_fifo #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata ({push_tag, push_dist}),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign pop_tag  = q_rdata[Q_W-1:DISTANCE_BITS];
	assign pop_dist = q_rdata[DISTANCE_BITS-1:0];

	lsmm_back #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.DISTANCE_BITS(DISTANCE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_tag     (pop_tag),
		.q_dist    (pop_dist),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sector_val(sector_val),
		.empty_mask(empty_sectors)
	);

	assign front       = sector_val[SEC_FRONT];
	assign front_right = sector_val[SEC_FRONT_RIGHT];
	assign rear_right  = sector_val[SEC_REAR_RIGHT];
	assign rear        = sector_val[SEC_REAR];
	assign rear_left   = sector_val[SEC_REAR_LEFT];
	assign front_left  = sector_val[SEC_FRONT_LEFT];

endmodule

### hw/rtl/lsmm_fifo.sv
// Short request queue between the classifying front and the accumulating back.
// Generic width and depth; no package dependency.
module lsmm_fifo #(
	parameter int WIDTH = 23,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("Queue written while full.");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("Queue read while empty.");

endmodule

### hw/rtl/lsmm_front.sv
// Front of the sector block: tracks the sample position and classifies each request
// into its sector before queueing it. Depends on lsmm_pkg.
module lsmm_front import lsmm_pkg::*; #(
	parameter int MAX_SAMPLES   = 1024,
	parameter int DISTANCE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lsmm_cfg_t                cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [DISTANCE_BITS-1:0] distance,
	input  logic                     q_full,
	output logic                     q_push,
	output lsmm_tag_t                q_tag,
	output logic [DISTANCE_BITS-1:0] q_dist
);

	localparam int POS_W = $clog2(MAX_SAMPLES);
	localparam int N_W   = $clog2(MAX_SAMPLES + 1);
	localparam int T_W   = N_W + 4;

	logic [POS_W-1:0] pos_q;
	logic [N_W-1:0]   n_eff;
	logic [N_W:0]     pos_inc;
	logic             last;
	logic [T_W-1:0]   t, n1, n3, n5, n7, n9, n11;
	logic [SEC_W-1:0] sector;

	always_comb begin
		if (cfg.samples_per_scan == '0) begin
			n_eff = N_W'(1);
		end else if (32'(cfg.samples_per_scan) > 32'(MAX_SAMPLES)) begin
			n_eff = N_W'(MAX_SAMPLES);
		end else begin
			n_eff = N_W'(cfg.samples_per_scan);
		end
	end

	assign t   = (T_W'(pos_q) << 3) + (T_W'(pos_q) << 2);
	assign n1  = T_W'(n_eff);
	assign n3  = (n1 << 1) + n1;
	assign n5  = (n1 << 2) + n1;
	assign n7  = (n1 << 3) - n1;
	assign n9  = (n1 << 3) + n1;
	assign n11 = (n1 << 3) + (n1 << 1) + n1;

	always_comb begin
		if (t < n1 || t >= n11) begin
			sector = SEC_FRONT;
		end else if (t < n3) begin
			sector = SEC_FRONT_RIGHT;
		end else if (t < n5) begin
			sector = SEC_REAR_RIGHT;
		end else if (t < n7) begin
			sector = SEC_REAR;
		end else if (t < n9) begin
			sector = SEC_REAR_LEFT;
		end else begin
			sector = SEC_FRONT_LEFT;
		end
	end

	assign pos_inc = (N_W + 1)'(pos_q) + 1'b1;
	assign last    = (pos_inc >= (N_W + 1)'(n_eff));

	assign in_ready     = !q_full;
	assign q_push       = in_valid && !q_full;
	assign q_dist       = distance;
	assign q_tag.sector = sector;
	assign q_tag.hit    = |distance;
	assign q_tag.last   = last;
	assign q_tag.mode   = cfg.zone_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (q_push) begin
			pos_q <= last ? '0 : pos_inc[POS_W-1:0];
		end
	end

endmodule

### hw/rtl/lsmm_div.sv
// Restoring divider, one quotient bit per cycle, for the sector means.
// No package dependency.
module lsmm_div #(
	parameter int DVD_W = 26,
	parameter int DVS_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial    = {rem_q, quo_q[DVD_W-1]};
	assign ge       = (trial >= {1'b0, dvs_q});
	assign diff     = trial - {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule

### hw/rtl/lsmm_back.sv
// Back of the sector block: applies queued requests to the sector accumulators and
// at scan end forms the six sector values, means via lsmm_div. Depends on lsmm_pkg.
module lsmm_back import lsmm_pkg::*; #(
	parameter int MAX_SAMPLES   = 1024,
	parameter int DISTANCE_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lsmm_cfg_t                cfg,
	input  logic                     q_empty,
	input  lsmm_tag_t                q_tag,
	input  logic [DISTANCE_BITS-1:0] q_dist,
	output logic                     q_pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [DISTANCE_BITS-1:0] sector_val [NUM_SECTORS],
	output logic [NUM_SECTORS-1:0]   empty_mask
);

	localparam int ACC_W = DISTANCE_BITS + ACC_EXTRA;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	localparam logic [1:0] ST_RUN  = 2'd0;
	localparam logic [1:0] ST_PICK = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic [1:0]               state_q;
	logic [ACC_W-1:0]         acc_q [NUM_SECTORS];
	logic [CNT_W-1:0]         cnt_q [NUM_SECTORS];
	logic [SEC_W-1:0]         sec_q;
	logic                     fin_mode_q;
	logic                     pend_q;
	logic                     out_valid_q;
	logic [DISTANCE_BITS-1:0] res_q [NUM_SECTORS];
	logic [NUM_SECTORS-1:0]   res_mask_q;
	logic [DISTANCE_BITS-1:0] out_val_q [NUM_SECTORS];
	logic [NUM_SECTORS-1:0]   out_mask_q;

	logic [SEC_W-1:0]         rd_sec;
	logic [ACC_W-1:0]         acc_rd;
	logic [CNT_W-1:0]         cnt_rd;
	logic [ACC_W:0]           sum;
	logic [ACC_W-1:0]         dist_x;
	logic [ACC_W-1:0]         acc_new;
	logic [CNT_W-1:0]         cnt_new;
	logic [DISTANCE_BITS-1:0] sat_acc;
	logic [DISTANCE_BITS-1:0] sat_quo;
	logic [DISTANCE_BITS-1:0] res_new;
	logic [ACC_W-1:0]         reload;
	logic                     need_div;
	logic                     adv;
	logic                     last_sec;
	logic                     out_take;
	logic                     div_start;
	logic                     div_done;
	logic [ACC_W-1:0]         div_quo;

	assign rd_sec = (state_q == ST_RUN) ? q_tag.sector : sec_q;
	assign acc_rd = acc_q[rd_sec];
	assign cnt_rd = cnt_q[rd_sec];

	assign q_pop = (state_q == ST_RUN) && !q_empty && !(q_tag.last && pend_q);

	assign dist_x = ACC_W'(q_dist);
	assign sum    = {1'b0, acc_rd} + {1'b0, dist_x};

	always_comb begin
		if (q_tag.mode == MODE_MEAN) begin
			acc_new = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
		end else begin
			acc_new = (dist_x < acc_rd) ? dist_x : acc_rd;
		end
	end

	assign cnt_new = (cnt_rd < CNT_W'(MAX_SAMPLES)) ? cnt_rd + 1'b1 : cnt_rd;

	assign sat_acc = (|acc_rd[ACC_W-1:DISTANCE_BITS]) ? '1 : acc_rd[DISTANCE_BITS-1:0];
	assign sat_quo = (|div_quo[ACC_W-1:DISTANCE_BITS]) ? '1 : div_quo[DISTANCE_BITS-1:0];

	assign need_div  = (fin_mode_q == MODE_MEAN) && (cnt_rd != '0);
	assign div_start = (state_q == ST_PICK) && need_div;
	assign adv       = ((state_q == ST_PICK) && !need_div) || ((state_q == ST_DIV) && div_done);
	assign last_sec  = (sec_q == SEC_FRONT_LEFT);
	assign out_take  = pend_q && (!out_valid_q || out_ready);
	assign reload    = (cfg.zone_mode == MODE_MEAN) ? '0 : ACC_W'(cfg.range_limit);

	always_comb begin
		if (state_q == ST_DIV) begin
			res_new = sat_quo;
		end else if (fin_mode_q == MODE_MEAN) begin
			res_new = '0;
		end else begin
			res_new = sat_acc;
		end
	end

	lsmm_div #(
		.DVD_W(ACC_W),
		.DVS_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(acc_rd),
		.divisor (cnt_rd),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			sec_q       <= SEC_FRONT;
			fin_mode_q  <= MODE_RST;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int s = 0; s < NUM_SECTORS; s++) begin
				acc_q[s] <= ACC_W'(RANGE_RST);
				cnt_q[s] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (q_pop) begin
						if (q_tag.hit) begin
							acc_q[q_tag.sector] <= acc_new;
							cnt_q[q_tag.sector] <= cnt_new;
						end
						if (q_tag.last) begin
							fin_mode_q <= q_tag.mode;
							sec_q      <= SEC_FRONT;
							state_q    <= ST_PICK;
						end
					end
				end
				ST_PICK: begin
					if (need_div) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase

			if (adv) begin
				if (last_sec) begin
					for (int s = 0; s < NUM_SECTORS; s++) begin
						acc_q[s] <= reload;
						cnt_q[s] <= '0;
					end
					state_q <= ST_RUN;
				end else begin
					sec_q   <= sec_q + 1'b1;
					state_q <= ST_PICK;
				end
			end

			if (adv && last_sec) begin
				pend_q <= 1'b1;
			end else if (out_take) begin
				pend_q <= 1'b0;
			end

			if (out_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q[sec_q]      <= res_new;
			res_mask_q[sec_q] <= (cnt_rd == '0);
		end
		if (out_take) begin
			out_val_q  <= res_q;
			out_mask_q <= res_mask_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign sector_val = out_val_q;
	assign empty_mask = out_mask_q;

	a_out_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pend_q))
		else $error("Result presented without a finished scan.");
	a_div_mean_only: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (fin_mode_q == MODE_MEAN))
		else $error("Division started outside mean mode.");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("Divider finished while not awaited.");

endmodule

### test/tb_lidar_sector_min_mean_top.sv
// Self-checking testbench for lidar_sector_min_mean_top: drives distance requests,
// predicts the per-scan sector summaries and checks every result as it arrives.
// Depends on lsmm_pkg and the block's top level.
module tb_lidar_sector_min_mean_top;
	import lsmm_pkg::*;

	localparam int DIST_W        = 16;
	localparam int MAX_SAMPLES   = 1024;
	localparam int RANDOM_ITEMS  = 1700;
	localparam int SETTLE_CYCLES = 400;
	localparam int CYCLE_LIMIT   = 3000000;
	localparam longint unsigned ACC_CAP = (64'd1 << (DIST_W + ACC_EXTRA)) - 1;

	typedef struct packed {
		logic [NUM_SECTORS-1:0]             empty;
		logic [NUM_SECTORS-1:0][DIST_W-1:0] value;
	} scan_summary_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_SAMPLES_PER_SCAN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [DIST_W-1:0]     distance = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [DIST_W-1:0]     front, front_right, rear_right, rear, rear_left, front_left;
	logic [NUM_SECTORS-1:0] empty_sectors;
	logic [NUM_SECTORS-1:0][DIST_W-1:0] seen_sectors;

	logic [DIST_W-1:0] pending_distances [$];
	scan_summary_t     expected_summaries [$];
	int                send_idle_pct = 0;
	int                recv_stall_pct = 0;
	int                error_count = 0;
	int                cycle_count = 0;

	logic [SPS_W-1:0]   cfg_sps;
	logic [RANGE_W-1:0] cfg_range;
	logic               cfg_mode;
	int unsigned        scan_pos;
	longint unsigned    sector_acc [NUM_SECTORS];
	int unsigned        sector_hits [NUM_SECTORS];

	assign seen_sectors = {front_left, rear_left, rear, rear_right, front_right, front};

	lidar_sector_min_mean_top #(
		.MAX_SAMPLES  (MAX_SAMPLES),
		.DISTANCE_BITS(DIST_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.distance     (distance),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.front        (front),
		.front_right  (front_right),
		.rear_right   (rear_right),
		.rear         (rear),
		.rear_left    (rear_left),
		.front_left   (front_left),
		.empty_sectors(empty_sectors)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [SEC_W-1:0] sector_for(input int unsigned pos, input int unsigned n);
		int unsigned t;
		t = pos * 12;
		if (t < n || t >= 11 * n) return SEC_FRONT;
		if (t < 3 * n) return SEC_FRONT_RIGHT;
		if (t < 5 * n) return SEC_REAR_RIGHT;
		if (t < 7 * n) return SEC_REAR;
		if (t < 9 * n) return SEC_REAR_LEFT;
		return SEC_FRONT_LEFT;
	endfunction

	task automatic reload_sectors();
		for (int s = 0; s < NUM_SECTORS; s++) begin
			sector_acc[s] = (cfg_mode == MODE_MEAN) ? 64'd0 : 64'(cfg_range);
			sector_hits[s] = 0;
		end
		scan_pos = 0;
	endtask

	task automatic absorb_sample(input logic [DIST_W-1:0] d);
		int unsigned n;
		logic [SEC_W-1:0] sec;
		longint unsigned v;
		scan_summary_t summary;
		n = (cfg_sps == 0) ? 1 : ((cfg_sps > MAX_SAMPLES) ? MAX_SAMPLES : cfg_sps);
		if (d != 0) begin
			sec = sector_for(scan_pos, n);
			if (cfg_mode == MODE_MEAN) begin
				v = sector_acc[sec] + 64'(d);
				sector_acc[sec] = (v > ACC_CAP) ? ACC_CAP : v;
			end else if (64'(d) < sector_acc[sec]) begin
				sector_acc[sec] = 64'(d);
			end
			if (sector_hits[sec] < MAX_SAMPLES) sector_hits[sec]++;
		end
		if (scan_pos + 1 < n) begin
			scan_pos++;
		end else begin
			for (int s = 0; s < NUM_SECTORS; s++) begin
				summary.empty[s] = (sector_hits[s] == 0);
				if (cfg_mode == MODE_MEAN)
					v = (sector_hits[s] == 0) ? 64'd0 : sector_acc[s] / sector_hits[s];
				else
					v = sector_acc[s];
				summary.value[s] = (v > 64'hFFFF) ? 16'hFFFF : v[DIST_W-1:0];
			end
			expected_summaries.push_back(summary);
			reload_sectors();
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_SAMPLES_PER_SCAN: cfg_sps = cfg_data[SPS_W-1:0];
					REG_RANGE_LIMIT: cfg_range = cfg_data[RANGE_W-1:0];
					REG_ZONE_MODE: cfg_mode = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) absorb_sample(distance);
			if (!in_valid || in_ready) begin
				if (pending_distances.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					distance <= pending_distances.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_check
		scan_summary_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_summaries.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual %h empty %b",
						$time, seen_sectors, empty_sectors);
				end else begin
					want = expected_summaries.pop_front();
					for (int s = 0; s < NUM_SECTORS; s++) begin
						if (seen_sectors[s] !== want.value[s]) begin
							error_count++;
							$display("%0t: sector %0d expected %0d actual %0d",
								$time, s, want.value[s], seen_sectors[s]);
						end
					end
					if (empty_sectors !== want.empty) begin
						error_count++;
						$display("%0t: empty_sectors expected %b actual %b",
							$time, want.empty, empty_sectors);
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic drain_and_settle();
		while (pending_distances.size() != 0 || in_valid || expected_summaries.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned phase;
		int unsigned random_sent;
		int unsigned batch;
		int unsigned eff_len;
		logic [SPS_W-1:0] sps_pick;
		logic [RANGE_W-1:0] range_pick;
		logic [4:0] sps_junk;
		logic [14:0] mode_junk;
		logic [DIST_W-1:0] d;

		cfg_sps = SPS_RST;
		cfg_range = RANGE_RST;
		cfg_mode = MODE_RST;
		reload_sectors();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// The first scan still starts from the reset range limit.
		drain_and_settle();
		write_register(REG_SAMPLES_PER_SCAN, 16'd12);
		write_register(REG_RANGE_LIMIT, 16'hFFFF);
		@(negedge clk);
		pending_distances = {pending_distances, 16'd0, 16'hFFFF, 16'd1, 16'd9000, 16'd7999,
			16'hFFFF, 16'd0, 16'd100, 16'd200, 16'd0, 16'd0, 16'd0};

		// Mean mode over minimum-mode starting values drives the quotient past the field.
		drain_and_settle();
		write_register(REG_ZONE_MODE, {15'd0, MODE_MEAN});
		write_register(REG_SAMPLES_PER_SCAN, 16'd1);
		@(negedge clk);
		pending_distances = {pending_distances, 16'hFFFF, 16'd1, 16'd0};

		drain_and_settle();
		write_register(REG_SAMPLES_PER_SCAN, 16'd0);
		@(negedge clk);
		pending_distances.push_back(16'h8000);

		// A long scan cut short by a smaller length written while samples are held.
		drain_and_settle();
		write_register(REG_SAMPLES_PER_SCAN, 16'd2047);
		@(negedge clk);
		pending_distances = {pending_distances, 16'd1, 16'd2, 16'd3, 16'hFFFF, 16'd0};
		drain_and_settle();
		write_register(REG_SAMPLES_PER_SCAN, 16'd3);
		@(negedge clk);
		pending_distances.push_back(16'd40);

		drain_and_settle();
		write_register(REG_RANGE_LIMIT, 16'd0);
		write_register(REG_ZONE_MODE, {15'd0, MODE_MIN});
		@(negedge clk);
		pending_distances = {pending_distances, 16'd5, 16'd6, 16'd7};

		random_sent = 0;
		for (phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
			drain_and_settle();
			case (phase % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 64; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 64; end
				default: begin send_idle_pct = 18; recv_stall_pct = 18; end
			endcase
			if (phase == 6) begin
				sps_pick = $urandom_range(1) ? 11'd1024 : 11'd2047;
			end else begin
				case ($urandom_range(9))
					0: sps_pick = 11'd0;
					1: sps_pick = SPS_W'($urandom_range(25, 120));
					default: sps_pick = SPS_W'($urandom_range(1, 24));
				endcase
			end
			case ($urandom_range(3))
				0: range_pick = 16'd0;
				1: range_pick = 16'hFFFF;
				default: range_pick = RANGE_W'($urandom);
			endcase
			sps_junk = 5'($urandom);
			mode_junk = 15'($urandom);
			if (phase == 6 || $urandom_range(3) != 0)
				write_register(REG_SAMPLES_PER_SCAN, {sps_junk, sps_pick});
			if ($urandom_range(2) != 0)
				write_register(REG_RANGE_LIMIT, range_pick);
			if ($urandom_range(2) != 0)
				write_register(REG_ZONE_MODE, {mode_junk, 1'($urandom_range(1))});
			eff_len = (cfg_sps == 0) ? 1 : ((cfg_sps > MAX_SAMPLES) ? MAX_SAMPLES : cfg_sps);
			if (eff_len >= 200)
				batch = eff_len + $urandom_range(0, 8);
			else
				batch = $urandom_range(1, 3) * eff_len + $urandom_range(0, eff_len - 1);
			@(negedge clk);
			repeat (batch) begin
				case ($urandom_range(7))
					0: d = '0;
					1: d = '1;
					2: d = DIST_W'($urandom_range(1, 15));
					default: d = DIST_W'($urandom);
				endcase
				pending_distances.push_back(d);
			end
			random_sent += batch;
		end

		drain_and_settle();
		if (expected_summaries.size() != 0) begin
			error_count += expected_summaries.size();
			$display("%0t: %0d expected results never arrived", $time, expected_summaries.size());
		end
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/lsmm_pkg.sv
hw/rtl/lsmm_fifo.sv
hw/rtl/lsmm_front.sv
hw/rtl/lsmm_div.sv
hw/rtl/lsmm_back.sv
hw/rtl/lidar_sector_min_mean_top.sv
test/tb_lidar_sector_min_mean_top.sv
